[sv/wbrp_pkg.sv]
package wbrp_pkg;

  // Result kinds on the output stream.
  localparam logic [2:0] EV_KEY  = 3'd0;
  localparam logic [2:0] EV_VAL  = 3'd1;
  localparam logic [2:0] EV_DONE = 3'd2;
  localparam logic [2:0] EV_OK   = 3'd3;
  localparam logic [2:0] EV_ERR  = 3'd4;

  // Batch status codes.
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_SMALL = 3'd1;
  localparam logic [2:0] ERR_PUT   = 3'd2;
  localparam logic [2:0] ERR_DEL   = 3'd3;
  localparam logic [2:0] ERR_TAG   = 3'd4;
  localparam logic [2:0] ERR_COUNT = 3'd5;

  localparam int HEADER_BYTES = 12;
  localparam int SEQ_BYTES    = 8;
  localparam int TDATA_W      = 80;

  // Everything one input byte can produce, in emission order:
  // payload event, record close, batch status.
  typedef struct packed {
    logic        pay_v;
    logic        pay_is_val;
    logic [7:0]  pay_byte;
    logic        is_put;
    logic        done_v;
    logic [63:0] seq;
    logic        stat_v;
    logic [2:0]  stat_code;
  } bundle_t;

endpackage

[sv/wbrp_parser.sv]
module wbrp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_end,
  output wbrp_pkg::bundle_t res,
  output logic              res_valid,
  input  logic              res_take
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_TAG     = 3'd1;
  localparam logic [2:0] PH_KEYLEN  = 3'd2;
  localparam logic [2:0] PH_KEYDATA = 3'd3;
  localparam logic [2:0] PH_VALLEN  = 3'd4;
  localparam logic [2:0] PH_VALDATA = 3'd5;
  localparam logic [2:0] PH_SWALLOW = 3'd6;

  logic        advance_sequence;
  logic [2:0]  phase, phase_next;
  logic [3:0]  hdr_pos, hdr_pos_next;
  logic [63:0] base_seq, base_seq_next;
  logic [31:0] exp_count, exp_count_next;
  logic [31:0] seen, seen_next;
  logic        is_put, is_put_next;
  logic [31:0] len_acc, len_acc_next;
  logic [2:0]  vpos, vpos_next;
  logic [31:0] remaining, remaining_next;
  logic [2:0]  perr, perr_next;

  wbrp_pkg::bundle_t res_next;
  logic        accept;
  logic        part_end;
  logic        part_is_key;
  logic [31:0] vshift;
  logic [31:0] merged;
  logic [31:0] rem_dec;
  logic [31:0] seq_offset;

  assign res_valid = res.pay_v | res.done_v | res.stat_v;
  assign in_ready  = !res_valid || res_take;
  assign accept    = in_valid && in_ready;

  // Payload bits of a varint byte placed at its group position (only the low four in the fifth byte).
  always_comb begin
    unique case (vpos)
      3'd0:    vshift = {25'd0, in_byte[6:0]};
      3'd1:    vshift = {18'd0, in_byte[6:0], 7'd0};
      3'd2:    vshift = {11'd0, in_byte[6:0], 14'd0};
      3'd3:    vshift = {4'd0, in_byte[6:0], 21'd0};
      3'd4:    vshift = {in_byte[3:0], 28'd0};
      default: vshift = 32'd0;
    endcase
  end

  assign merged     = len_acc | vshift;
  assign rem_dec    = remaining - 32'd1;
  assign seq_offset = advance_sequence ? (seen - 32'd1) : 32'd0;

  always_comb begin
    phase_next     = phase;
    hdr_pos_next   = hdr_pos;
    base_seq_next  = base_seq;
    exp_count_next = exp_count;
    seen_next      = seen;
    is_put_next    = is_put;
    len_acc_next   = len_acc;
    vpos_next      = vpos;
    remaining_next = remaining;
    perr_next      = perr;
    part_end       = 1'b0;
    part_is_key    = 1'b0;
    res_next       = '0;
    res_next.is_put = is_put;

    unique case (phase)
      PH_HEADER: begin
        if (hdr_pos < 4'(wbrp_pkg::SEQ_BYTES)) begin
          base_seq_next[{hdr_pos[2:0], 3'b000} +: 8] = in_byte;
        end else begin
          exp_count_next[{hdr_pos[1:0], 3'b000} +: 8] = in_byte;
        end
        hdr_pos_next = hdr_pos + 4'd1;
        if (hdr_pos == 4'(wbrp_pkg::HEADER_BYTES - 1)) begin
          phase_next = PH_TAG;
        end
      end
      PH_TAG: begin
        seen_next = seen + 32'd1;
        if (in_byte[7:1] == 7'd0) begin
          is_put_next  = in_byte[0];
          phase_next   = PH_KEYLEN;
          vpos_next    = 3'd0;
          len_acc_next = 32'd0;
        end else begin
          perr_next  = wbrp_pkg::ERR_TAG;
          phase_next = PH_SWALLOW;
        end
      end
      PH_KEYLEN, PH_VALLEN: begin
        if (in_byte[7]) begin
          len_acc_next = merged;
          if (vpos >= 3'd4) begin
            perr_next  = is_put ? wbrp_pkg::ERR_PUT : wbrp_pkg::ERR_DEL;
            phase_next = PH_SWALLOW;
          end else begin
            vpos_next = vpos + 3'd1;
          end
        end else begin
          remaining_next = merged;
          len_acc_next   = 32'd0;
          vpos_next      = 3'd0;
          if (merged != 32'd0) begin
            phase_next = (phase == PH_KEYLEN) ? PH_KEYDATA : PH_VALDATA;
          end else begin
            part_end    = 1'b1;
            part_is_key = (phase == PH_KEYLEN);
          end
        end
      end
      PH_KEYDATA, PH_VALDATA: begin
        res_next.pay_v      = 1'b1;
        res_next.pay_is_val = (phase == PH_VALDATA);
        res_next.pay_byte   = in_byte;
        remaining_next      = rem_dec;
        if (rem_dec == 32'd0) begin
          part_end    = 1'b1;
          part_is_key = (phase == PH_KEYDATA);
        end
      end
      default: begin
      end
    endcase

    // A finished key of a put moves on to the value length; anything else
    // closes the record.
    if (part_end) begin
      if (part_is_key && is_put) begin
        phase_next   = PH_VALLEN;
        vpos_next    = 3'd0;
        len_acc_next = 32'd0;
      end else begin
        phase_next      = PH_TAG;
        res_next.done_v = 1'b1;
        res_next.seq    = base_seq + {32'd0, seq_offset};
      end
    end

    // The status reflects the state after this byte, including a tag that
    // arrives on the final byte.
    if (in_end) begin
      res_next.stat_v = 1'b1;
      unique case (phase_next)
        PH_HEADER:  res_next.stat_code = wbrp_pkg::ERR_SMALL;
        PH_TAG:     res_next.stat_code = (seen_next == exp_count_next) ?
                                         wbrp_pkg::ERR_NONE : wbrp_pkg::ERR_COUNT;
        PH_SWALLOW: res_next.stat_code = perr_next;
        default:    res_next.stat_code = is_put_next ? wbrp_pkg::ERR_PUT
                                                     : wbrp_pkg::ERR_DEL;
      endcase
      phase_next     = PH_HEADER;
      hdr_pos_next   = 4'd0;
      base_seq_next  = 64'd0;
      exp_count_next = 32'd0;
      seen_next      = 32'd0;
      is_put_next    = 1'b0;
      len_acc_next   = 32'd0;
      vpos_next      = 3'd0;
      remaining_next = 32'd0;
      perr_next      = wbrp_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      advance_sequence <= 1'b1;
    end else if (cfg_we) begin
      advance_sequence <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      hdr_pos   <= 4'd0;
      base_seq  <= 64'd0;
      exp_count <= 32'd0;
      seen      <= 32'd0;
      is_put    <= 1'b0;
      len_acc   <= 32'd0;
      vpos      <= 3'd0;
      remaining <= 32'd0;
      perr      <= wbrp_pkg::ERR_NONE;
    end else if (accept) begin
      phase     <= phase_next;
      hdr_pos   <= hdr_pos_next;
      base_seq  <= base_seq_next;
      exp_count <= exp_count_next;
      seen      <= seen_next;
      is_put    <= is_put_next;
      len_acc   <= len_acc_next;
      vpos      <= vpos_next;
      remaining <= remaining_next;
      perr      <= perr_next;
    end
  end

  // Result register: a byte that produces nothing leaves it empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.pay_v  <= 1'b0;
      res.done_v <= 1'b0;
      res.stat_v <= 1'b0;
    end else if (accept) begin
      res.pay_v  <= res_next.pay_v;
      res.done_v <= res_next.done_v;
      res.stat_v <= res_next.stat_v;
    end else if (res_take) begin
      res.pay_v  <= 1'b0;
      res.done_v <= 1'b0;
      res.stat_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.pay_is_val <= res_next.pay_is_val;
      res.pay_byte   <= res_next.pay_byte;
      res.is_put     <= res_next.is_put;
      res.seq        <= res_next.seq;
      res.stat_code  <= res_next.stat_code;
    end
  end

endmodule

[sv/wbrp_serializer.sv]
module wbrp_serializer (
  input  logic              clk,
  input  logic              rst,
  input  wbrp_pkg::bundle_t res,
  input  logic              res_valid,
  output logic              res_take,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [wbrp_pkg::TDATA_W-1:0] m_tdata,
  output logic [2:0]        m_tuser,
  output logic              m_tlast
);

  wbrp_pkg::bundle_t hold;
  logic [1:0] pending;
  logic       one_left;
  logic       pop;

  assign pending  = {1'b0, hold.pay_v} + {1'b0, hold.done_v} + {1'b0, hold.stat_v};
  assign one_left = (pending == 2'd1);
  assign m_tvalid = (pending != 2'd0);
  assign m_tlast  = one_left;
  assign pop      = m_tvalid && m_tready;
  // The next bundle moves in as soon as the last event of this one leaves.
  assign res_take = res_valid && (!m_tvalid || (one_left && m_tready));

  always_ff @(posedge clk) begin
    if (rst) begin
      hold.pay_v  <= 1'b0;
      hold.done_v <= 1'b0;
      hold.stat_v <= 1'b0;
    end else if (res_take) begin
      hold.pay_v  <= res.pay_v;
      hold.done_v <= res.done_v;
      hold.stat_v <= res.stat_v;
    end else if (pop) begin
      priority if (hold.pay_v) begin
        hold.pay_v <= 1'b0;
      end else if (hold.done_v) begin
        hold.done_v <= 1'b0;
      end else begin
        hold.stat_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      hold.pay_is_val <= res.pay_is_val;
      hold.pay_byte   <= res.pay_byte;
      hold.is_put     <= res.is_put;
      hold.seq        <= res.seq;
      hold.stat_code  <= res.stat_code;
    end
  end

  always_comb begin
    logic [7:0]  o_byte;
    logic        o_put;
    logic [63:0] o_seq;
    logic [2:0]  o_err;
    o_byte  = 8'd0;
    o_put   = 1'b0;
    o_seq   = 64'd0;
    o_err   = wbrp_pkg::ERR_NONE;
    m_tuser = wbrp_pkg::EV_KEY;
    priority if (hold.pay_v) begin
      m_tuser = hold.pay_is_val ? wbrp_pkg::EV_VAL : wbrp_pkg::EV_KEY;
      o_byte  = hold.pay_byte;
      o_put   = hold.is_put;
    end else if (hold.done_v) begin
      m_tuser = wbrp_pkg::EV_DONE;
      o_put   = hold.is_put;
      o_seq   = hold.seq;
    end else if (hold.stat_v) begin
      m_tuser = (hold.stat_code == wbrp_pkg::ERR_NONE) ? wbrp_pkg::EV_OK : wbrp_pkg::EV_ERR;
      o_err   = hold.stat_code;
    end
    m_tdata = {4'd0, o_err, o_seq, o_put, o_byte};
  end

endmodule

[sv/write_batch_record_parser.sv]
// Channel  Fields (lowest bit up)                                  Direction
// s_       tdata: data_byte; tlast: batch_end                      in
// m_       tdata: payload_byte, record_is_put, record_sequence,    out
//          error_code, zero pad; tuser: event_res; tlast: last_of_run
// cfg_     we/wdata: advance_sequence                              in
//
// One input byte is taken per cycle while s_tready is high; it is parsed in the
// cycle it is accepted, its results are in the result register the next cycle,
// and the first of them is moved on to the output register and offered on m_.
// A byte yields up to three output transfers, one per cycle while m_tready is
// high; once the result register also holds a bundle, the input waits until the
// output register is empty or its last transfer leaves. Bytes that produce no
// result are still taken. Synchronous reset returns the parser to the header and
// sets advance_sequence to 1.
module write_batch_record_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // batch_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // payload_byte, record_is_put, record_sequence,
                                 // error_code, pad
  output logic [2:0]  m_tuser,   // event_res
  output logic        m_tlast    // last_of_run
);

  wbrp_pkg::bundle_t res;
  logic res_valid;
  logic res_take;

  wbrp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_end    (s_tlast),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take)
  );

  wbrp_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

[sv/wbrp_checker.sv]
module wbrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled transfer stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output transfer withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("output payload changed while stalled");

  // A batch status is always the final result of its byte.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == wbrp_pkg::EV_OK || m_tuser == wbrp_pkg::EV_ERR) |-> m_tlast)
    else $error("batch status not marked last");

  // Error codes appear only on error events, and an error event carries one.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == wbrp_pkg::EV_ERR) == (m_tdata[75:73] != wbrp_pkg::ERR_NONE)))
    else $error("error code does not match event kind");

  // Only key and value events carry a payload byte.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == wbrp_pkg::EV_DONE || m_tuser == wbrp_pkg::EV_OK ||
                 m_tuser == wbrp_pkg::EV_ERR) |-> m_tdata[7:0] == 8'd0)
    else $error("payload byte on a non-payload event");

endmodule

bind write_batch_record_parser wbrp_checker u_wbrp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
